FILE: rtl/core/lts_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lts_pkg
// Shared types and constants for the lexical token scanner: lexer modes,
// comment marks, token types, error codes, character codes and result format.
// ----------------------------------------------------------------------------
package lts_pkg;

  // Fixed widths of the result fields
  localparam int unsigned OUT_BITS  = 24;
  localparam int unsigned TYPE_BITS = 5;
  localparam int unsigned CODE_BITS = 3;

  // Result queue: room for the worst case of one item (three results)
  localparam int unsigned MAX_PER_ITEM = 3;
  localparam int unsigned FIFO_DEPTH   = 4;
  localparam int unsigned PTR_BITS     = $clog2(FIFO_DEPTH);
  localparam int unsigned CNT_BITS     = $clog2(FIFO_DEPTH + 1);
  localparam int unsigned SLOT_BITS    = $clog2(MAX_PER_ITEM + 1);

  typedef enum logic [3:0] {
    MODE_IDLE  = 4'd0,
    MODE_BANG  = 4'd1,
    MODE_EQ    = 4'd2,
    MODE_LT    = 4'd3,
    MODE_GT    = 4'd4,
    MODE_SLASH = 4'd5,
    MODE_LINE  = 4'd6,
    MODE_BLOCK = 4'd7,
    MODE_STR   = 4'd8,
    MODE_INT   = 4'd9,
    MODE_DOT   = 4'd10,
    MODE_FRAC  = 4'd11,
    MODE_IDENT = 4'd12
  } lts_mode_e;

  typedef enum logic [1:0] {
    MARK_NONE  = 2'd0,
    MARK_STAR  = 2'd1,
    MARK_SLASH = 2'd2
  } lts_mark_e;

  // Token types
  localparam logic [TYPE_BITS-1:0] T_LPAREN    = 5'd0;
  localparam logic [TYPE_BITS-1:0] T_RPAREN    = 5'd1;
  localparam logic [TYPE_BITS-1:0] T_LBRACE    = 5'd2;
  localparam logic [TYPE_BITS-1:0] T_RBRACE    = 5'd3;
  localparam logic [TYPE_BITS-1:0] T_COMMA     = 5'd4;
  localparam logic [TYPE_BITS-1:0] T_DOT       = 5'd5;
  localparam logic [TYPE_BITS-1:0] T_MINUS     = 5'd6;
  localparam logic [TYPE_BITS-1:0] T_PLUS      = 5'd7;
  localparam logic [TYPE_BITS-1:0] T_SEMICOLON = 5'd8;
  localparam logic [TYPE_BITS-1:0] T_STAR      = 5'd9;
  localparam logic [TYPE_BITS-1:0] T_BANG      = 5'd10;
  localparam logic [TYPE_BITS-1:0] T_EQUAL     = 5'd12;
  localparam logic [TYPE_BITS-1:0] T_GREATER   = 5'd14;
  localparam logic [TYPE_BITS-1:0] T_LESS      = 5'd16;
  localparam logic [TYPE_BITS-1:0] T_SLASH     = 5'd18;
  localparam logic [TYPE_BITS-1:0] T_STRING    = 5'd19;
  localparam logic [TYPE_BITS-1:0] T_NUMBER    = 5'd20;
  localparam logic [TYPE_BITS-1:0] T_IDENT     = 5'd21;
  localparam logic [TYPE_BITS-1:0] T_EOF       = 5'd22;

  // Error codes
  localparam logic [CODE_BITS-1:0] E_NONE        = 3'd0;
  localparam logic [CODE_BITS-1:0] E_UNEXPECTED  = 3'd1;
  localparam logic [CODE_BITS-1:0] E_OPEN_STRING = 3'd2;
  localparam logic [CODE_BITS-1:0] E_OPEN_CMT    = 3'd3;
  localparam logic [CODE_BITS-1:0] E_OPEN_NESTED = 3'd4;

  // Character codes
  localparam logic [7:0] CH_LPAREN = 8'h28;
  localparam logic [7:0] CH_RPAREN = 8'h29;
  localparam logic [7:0] CH_LBRACE = 8'h7b;
  localparam logic [7:0] CH_RBRACE = 8'h7d;
  localparam logic [7:0] CH_COMMA  = 8'h2c;
  localparam logic [7:0] CH_DOT    = 8'h2e;
  localparam logic [7:0] CH_MINUS  = 8'h2d;
  localparam logic [7:0] CH_PLUS   = 8'h2b;
  localparam logic [7:0] CH_SEMI   = 8'h3b;
  localparam logic [7:0] CH_STAR   = 8'h2a;
  localparam logic [7:0] CH_BANG   = 8'h21;
  localparam logic [7:0] CH_EQ     = 8'h3d;
  localparam logic [7:0] CH_LT     = 8'h3c;
  localparam logic [7:0] CH_GT     = 8'h3e;
  localparam logic [7:0] CH_SLASH  = 8'h2f;
  localparam logic [7:0] CH_SPACE  = 8'h20;
  localparam logic [7:0] CH_CR     = 8'h0d;
  localparam logic [7:0] CH_TAB    = 8'h09;
  localparam logic [7:0] CH_NL     = 8'h0a;
  localparam logic [7:0] CH_QUOTE  = 8'h22;
  localparam logic [7:0] CH_UNDER  = 8'h5f;
  localparam logic [7:0] CH_0      = 8'h30;
  localparam logic [7:0] CH_9      = 8'h39;
  localparam logic [7:0] CH_LA     = 8'h61;
  localparam logic [7:0] CH_LZ     = 8'h7a;
  localparam logic [7:0] CH_UA     = 8'h41;
  localparam logic [7:0] CH_UZ     = 8'h5a;

  typedef struct packed {
    logic                 is_error;
    logic [TYPE_BITS-1:0] token_type;
    logic [CODE_BITS-1:0] error_code;
    logic [OUT_BITS-1:0]  start_pos;
    logic [OUT_BITS-1:0]  token_len;
    logic [OUT_BITS-1:0]  line_no;
    logic                 last_of_run;
  } lts_result_t;

  function automatic logic is_digit(input logic [7:0] c);
    return (c >= CH_0) && (c <= CH_9);
  endfunction

  function automatic logic is_alpha(input logic [7:0] c);
    return ((c >= CH_LA) && (c <= CH_LZ)) || ((c >= CH_UA) && (c <= CH_UZ)) ||
           (c == CH_UNDER);
  endfunction

  // One-character type of a pending operator mode
  function automatic logic [TYPE_BITS-1:0] op_type(input lts_mode_e m);
    logic [TYPE_BITS-1:0] t;
    unique case (m)
      MODE_BANG: t = T_BANG;
      MODE_EQ:   t = T_EQUAL;
      MODE_LT:   t = T_LESS;
      MODE_GT:   t = T_GREATER;
      default:   t = T_BANG;
    endcase
    return t;
  endfunction

endpackage

FILE: rtl/core/lts_intf.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lts_intf
// Stream channels of the lexical token scanner: source bytes in, token and
// error results out, each with a valid/ready handshake.
// ----------------------------------------------------------------------------
interface lts_in_if;
  logic       valid;
  logic       ready;
  logic       action;
  logic [7:0] byte_req;

  modport source (output valid, action, byte_req, input ready);
  modport sink   (input valid, action, byte_req, output ready);
endinterface

interface lts_out_if;
  logic                           valid;
  logic                           ready;
  logic                           is_error;
  logic [lts_pkg::TYPE_BITS-1:0]  token_type;
  logic [lts_pkg::CODE_BITS-1:0]  error_code;
  logic [lts_pkg::OUT_BITS-1:0]   start_pos;
  logic [lts_pkg::OUT_BITS-1:0]   token_len;
  logic [lts_pkg::OUT_BITS-1:0]   line_no;
  logic                           last_of_run;

  modport source (output valid, is_error, token_type, error_code, start_pos,
                  token_len, line_no, last_of_run, input ready);
  modport sink   (input valid, is_error, token_type, error_code, start_pos,
                  token_len, line_no, last_of_run, output ready);
endinterface

FILE: rtl/core/lexical_token_scanner.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lexical_token_scanner
// Byte-at-a-time scanner for a Lox-style language with nested block
// comments. Emits tokens (type, start, length, line) and error reports.
// ----------------------------------------------------------------------------
//
//  Channel  Dir  Payload                                      Transfer when
//  -------  ---  -------------------------------------------  ----------------
//  in_i     in   action, byte_req                             valid && ready
//  out_o    out  is_error, token_type, error_code, start_pos, valid && ready
//                token_len, line_no, last_of_run
//
//  - One input transfer per cycle while in_i.ready is high; the lexer state
//    updates in the same cycle and its 0..3 results go to a 4-entry result queue.
//  - Results leave one per cycle while out_o is ready, the cycle after their
//    transfer at the earliest. Bytes are taken back to back while none causes
//    more than one result and out_o is ready; an item with two or three
//    results holds in_i.ready low until the queue is down to one entry.
//  - in_i.ready is high while the queue holds at most one result (room for
//    the worst case of three); it depends on registers only.
//  - Reset (rst_ni low, async) clears the lexer state and empties the queue.
//  - End of source flushes any pending token or error, adds an end-of-file
//    token and returns the lexer to its reset state.
//
module lexical_token_scanner #(
  parameter int unsigned POS_BITS  = 24,
  parameter int unsigned LINE_BITS = 24,
  parameter int unsigned NEST_BITS = 8
) (
  input  logic     clk_i,
  input  logic     rst_ni,
  lts_in_if.sink   in_i,
  lts_out_if.source out_o
);

  localparam int unsigned OB = lts_pkg::OUT_BITS;
  // Widths used to compare a counter against the result field maximum
  localparam int unsigned PW = (POS_BITS > OB) ? POS_BITS : OB;
  localparam int unsigned LW = (LINE_BITS > OB) ? LINE_BITS : OB;

  localparam logic [POS_BITS-1:0]  POS_ALL  = {POS_BITS{1'b1}};
  localparam logic [LINE_BITS-1:0] LINE_ALL = {LINE_BITS{1'b1}};
  localparam logic [NEST_BITS-1:0] NEST_ALL = {NEST_BITS{1'b1}};
  localparam logic [OB-1:0]        OUT_ALL  = {OB{1'b1}};

  // --------------------------------------------------------------------------
  // Lexer state
  // --------------------------------------------------------------------------
  lts_pkg::lts_mode_e    mode_q,  mode_d;
  lts_pkg::lts_mark_e    mark_q,  mark_d;
  logic [POS_BITS-1:0]   start_q, start_d;
  logic [POS_BITS-1:0]   pos_q,   pos_d;
  logic [LINE_BITS-1:0]  line_q,  line_d;
  logic [NEST_BITS-1:0]  nest_q,  nest_d;

  // Result queue
  lts_pkg::lts_result_t                fifo_q [lts_pkg::FIFO_DEPTH];
  logic [lts_pkg::PTR_BITS-1:0]        wptr_q, rptr_q;
  logic [lts_pkg::CNT_BITS-1:0]        count_q, count_d;

  logic in_fire, out_fire;
  assign in_fire  = in_i.valid && in_i.ready;
  assign out_fire = out_o.valid && out_o.ready;

  assign in_i.ready = (count_q <= lts_pkg::CNT_BITS'(lts_pkg::FIFO_DEPTH -
                                                      lts_pkg::MAX_PER_ITEM));

  // Saturate internal counters onto the 24-bit result fields
  function automatic logic [OB-1:0] clip_pos(input logic [POS_BITS-1:0] v);
    logic [PW-1:0] ext;
    ext = PW'(v);
    return (ext > PW'(OUT_ALL)) ? OUT_ALL : ext[OB-1:0];
  endfunction

  function automatic logic [OB-1:0] clip_line(input logic [LINE_BITS-1:0] v);
    logic [LW-1:0] ext;
    ext = LW'(v);
    return (ext > LW'(OUT_ALL)) ? OUT_ALL : ext[OB-1:0];
  endfunction

  function automatic lts_pkg::lts_result_t mk_res(
    input logic                          err,
    input logic [lts_pkg::TYPE_BITS-1:0] ttype,
    input logic [lts_pkg::CODE_BITS-1:0] code,
    input logic [POS_BITS-1:0]           start,
    input logic [POS_BITS-1:0]           len,
    input logic [LINE_BITS-1:0]          line
  );
    lts_pkg::lts_result_t r;
    r.is_error    = err;
    r.token_type  = ttype;
    r.error_code  = code;
    r.start_pos   = clip_pos(start);
    r.token_len   = clip_pos(len);
    r.line_no     = clip_line(line);
    r.last_of_run = 1'b0;
    return r;
  endfunction

  // --------------------------------------------------------------------------
  // Next state and results of one transfer
  // --------------------------------------------------------------------------
  logic [7:0]                        c;
  logic [POS_BITS-1:0]               p, endp, dotpos;
  logic [POS_BITS-1:0]               span_p, span_end, span_dot;
  logic [LINE_BITS-1:0]              line_inc;
  logic [NEST_BITS-1:0]              nest_dec;
  logic                              again;
  logic                              idle_emit, idle_err;
  logic [lts_pkg::TYPE_BITS-1:0]     idle_type;
  lts_pkg::lts_result_t              res [lts_pkg::MAX_PER_ITEM];
  logic [lts_pkg::SLOT_BITS-1:0]     n;

  always_comb begin
    c        = in_i.byte_req;
    p        = pos_q;
    endp     = (pos_q == POS_ALL) ? pos_q : pos_q + POS_BITS'(1);
    dotpos   = (pos_q > start_q) ? pos_q - POS_BITS'(1) : pos_q;
    span_p   = (pos_q >= start_q) ? pos_q - start_q : '0;
    span_end = (endp >= start_q) ? endp - start_q : '0;
    span_dot = (pos_q > start_q) ? pos_q - start_q - POS_BITS'(1) : '0;
    line_inc = (line_q == LINE_ALL) ? line_q : line_q + LINE_BITS'(1);
    nest_dec = (nest_q != '0) ? nest_q - NEST_BITS'(1) : nest_q;

    mode_d    = mode_q;
    mark_d    = mark_q;
    start_d   = start_q;
    pos_d     = pos_q;
    line_d    = line_q;
    nest_d    = nest_q;
    again     = 1'b0;
    idle_emit = 1'b0;
    idle_err  = 1'b0;
    idle_type = lts_pkg::T_LPAREN;
    n         = '0;
    for (int i = 0; i < lts_pkg::MAX_PER_ITEM; i++) begin
      res[i] = '0;
    end

    if (in_fire && in_i.action) begin
      // End of source: flush the pending lexeme, then end-of-file
      unique case (mode_q)
        lts_pkg::MODE_BANG, lts_pkg::MODE_EQ, lts_pkg::MODE_LT,
        lts_pkg::MODE_GT: begin
          res[n] = mk_res(1'b0, lts_pkg::op_type(mode_q), lts_pkg::E_NONE,
                          start_q, span_p, line_q);
          n = n + 1'b1;
        end
        lts_pkg::MODE_SLASH: begin
          res[n] = mk_res(1'b0, lts_pkg::T_SLASH, lts_pkg::E_NONE,
                          start_q, span_p, line_q);
          n = n + 1'b1;
        end
        lts_pkg::MODE_BLOCK: begin
          res[n] = mk_res(1'b1, lts_pkg::T_LPAREN,
                          (nest_q == NEST_BITS'(1)) ? lts_pkg::E_OPEN_CMT
                                                    : lts_pkg::E_OPEN_NESTED,
                          start_q, span_p, line_q);
          n = n + 1'b1;
        end
        lts_pkg::MODE_STR: begin
          res[n] = mk_res(1'b1, lts_pkg::T_LPAREN, lts_pkg::E_OPEN_STRING,
                          start_q, span_p, line_q);
          n = n + 1'b1;
        end
        lts_pkg::MODE_INT, lts_pkg::MODE_FRAC: begin
          res[n] = mk_res(1'b0, lts_pkg::T_NUMBER, lts_pkg::E_NONE,
                          start_q, span_p, line_q);
          n = n + 1'b1;
        end
        lts_pkg::MODE_DOT: begin
          res[n] = mk_res(1'b0, lts_pkg::T_NUMBER, lts_pkg::E_NONE,
                          start_q, span_dot, line_q);
          n = n + 1'b1;
          res[n] = mk_res(1'b0, lts_pkg::T_DOT, lts_pkg::E_NONE,
                          dotpos, POS_BITS'(1), line_q);
          n = n + 1'b1;
        end
        lts_pkg::MODE_IDENT: begin
          res[n] = mk_res(1'b0, lts_pkg::T_IDENT, lts_pkg::E_NONE,
                          start_q, span_p, line_q);
          n = n + 1'b1;
        end
        default: ;
      endcase
      res[n] = mk_res(1'b0, lts_pkg::T_EOF, lts_pkg::E_NONE, p, '0, line_q);
      n = n + 1'b1;

      mode_d  = lts_pkg::MODE_IDLE;
      mark_d  = lts_pkg::MARK_NONE;
      start_d = '0;
      pos_d   = '0;
      line_d  = LINE_BITS'(1);
      nest_d  = '0;
    end else if (in_fire) begin
      unique case (mode_q)
        lts_pkg::MODE_IDLE: again = 1'b1;
        lts_pkg::MODE_BANG, lts_pkg::MODE_EQ, lts_pkg::MODE_LT,
        lts_pkg::MODE_GT: begin
          mode_d = lts_pkg::MODE_IDLE;
          if (c == lts_pkg::CH_EQ) begin
            res[n] = mk_res(1'b0, lts_pkg::op_type(mode_q) + 5'd1,
                            lts_pkg::E_NONE, start_q, span_end, line_q);
            n = n + 1'b1;
          end else begin
            res[n] = mk_res(1'b0, lts_pkg::op_type(mode_q), lts_pkg::E_NONE,
                            start_q, span_p, line_q);
            n = n + 1'b1;
            again = 1'b1;
          end
        end
        lts_pkg::MODE_SLASH: begin
          if (c == lts_pkg::CH_SLASH) begin
            mode_d = lts_pkg::MODE_LINE;
          end else if (c == lts_pkg::CH_STAR) begin
            mode_d = lts_pkg::MODE_BLOCK;
            nest_d = NEST_BITS'(1);
            mark_d = lts_pkg::MARK_NONE;
          end else begin
            mode_d = lts_pkg::MODE_IDLE;
            res[n] = mk_res(1'b0, lts_pkg::T_SLASH, lts_pkg::E_NONE,
                            start_q, span_p, line_q);
            n = n + 1'b1;
            again = 1'b1;
          end
        end
        lts_pkg::MODE_LINE: begin
          if (c == lts_pkg::CH_NL) begin
            mode_d = lts_pkg::MODE_IDLE;
            again  = 1'b1;
          end
        end
        lts_pkg::MODE_BLOCK: begin
          if (mark_q == lts_pkg::MARK_STAR && c == lts_pkg::CH_SLASH) begin
            // close one level; both bytes are consumed
            nest_d = nest_dec;
            mark_d = lts_pkg::MARK_NONE;
            if (nest_dec == '0) mode_d = lts_pkg::MODE_IDLE;
          end else if (mark_q == lts_pkg::MARK_SLASH && c == lts_pkg::CH_STAR) begin
            nest_d = (nest_q == NEST_ALL) ? nest_q : nest_q + NEST_BITS'(1);
            mark_d = lts_pkg::MARK_NONE;
          end else begin
            if (c == lts_pkg::CH_NL) line_d = line_inc;
            if (c == lts_pkg::CH_STAR)       mark_d = lts_pkg::MARK_STAR;
            else if (c == lts_pkg::CH_SLASH) mark_d = lts_pkg::MARK_SLASH;
            else                             mark_d = lts_pkg::MARK_NONE;
          end
        end
        lts_pkg::MODE_STR: begin
          if (c == lts_pkg::CH_QUOTE) begin
            mode_d = lts_pkg::MODE_IDLE;
            res[n] = mk_res(1'b0, lts_pkg::T_STRING, lts_pkg::E_NONE,
                            start_q, span_end, line_q);
            n = n + 1'b1;
          end else if (c == lts_pkg::CH_NL) begin
            line_d = line_inc;
          end
        end
        lts_pkg::MODE_INT: begin
          if (c == lts_pkg::CH_DOT) begin
            mode_d = lts_pkg::MODE_DOT;
          end else if (!lts_pkg::is_digit(c)) begin
            mode_d = lts_pkg::MODE_IDLE;
            res[n] = mk_res(1'b0, lts_pkg::T_NUMBER, lts_pkg::E_NONE,
                            start_q, span_p, line_q);
            n = n + 1'b1;
            again = 1'b1;
          end
        end
        lts_pkg::MODE_DOT: begin
          if (lts_pkg::is_digit(c)) begin
            mode_d = lts_pkg::MODE_FRAC;
          end else begin
            // "12." then a non-digit: number without the dot, then the dot
            mode_d = lts_pkg::MODE_IDLE;
            res[n] = mk_res(1'b0, lts_pkg::T_NUMBER, lts_pkg::E_NONE,
                            start_q, span_dot, line_q);
            n = n + 1'b1;
            res[n] = mk_res(1'b0, lts_pkg::T_DOT, lts_pkg::E_NONE,
                            dotpos, POS_BITS'(1), line_q);
            n = n + 1'b1;
            again = 1'b1;
          end
        end
        lts_pkg::MODE_FRAC: begin
          if (!lts_pkg::is_digit(c)) begin
            mode_d = lts_pkg::MODE_IDLE;
            res[n] = mk_res(1'b0, lts_pkg::T_NUMBER, lts_pkg::E_NONE,
                            start_q, span_p, line_q);
            n = n + 1'b1;
            again = 1'b1;
          end
        end
        lts_pkg::MODE_IDENT: begin
          if (!lts_pkg::is_alpha(c) && !lts_pkg::is_digit(c)) begin
            mode_d = lts_pkg::MODE_IDLE;
            res[n] = mk_res(1'b0, lts_pkg::T_IDENT, lts_pkg::E_NONE,
                            start_q, span_p, line_q);
            n = n + 1'b1;
            again = 1'b1;
          end
        end
        default: begin
          mode_d = lts_pkg::MODE_IDLE;
          again  = 1'b1;
        end
      endcase

      // Byte seen from idle: either ended a lexeme above or arrived in idle
      if (again) begin
        start_d = p;
        case (c)
          lts_pkg::CH_LPAREN: begin idle_emit = 1'b1; idle_type = lts_pkg::T_LPAREN; end
          lts_pkg::CH_RPAREN: begin idle_emit = 1'b1; idle_type = lts_pkg::T_RPAREN; end
          lts_pkg::CH_LBRACE: begin idle_emit = 1'b1; idle_type = lts_pkg::T_LBRACE; end
          lts_pkg::CH_RBRACE: begin idle_emit = 1'b1; idle_type = lts_pkg::T_RBRACE; end
          lts_pkg::CH_COMMA:  begin idle_emit = 1'b1; idle_type = lts_pkg::T_COMMA; end
          lts_pkg::CH_DOT:    begin idle_emit = 1'b1; idle_type = lts_pkg::T_DOT; end
          lts_pkg::CH_MINUS:  begin idle_emit = 1'b1; idle_type = lts_pkg::T_MINUS; end
          lts_pkg::CH_PLUS:   begin idle_emit = 1'b1; idle_type = lts_pkg::T_PLUS; end
          lts_pkg::CH_SEMI:   begin idle_emit = 1'b1; idle_type = lts_pkg::T_SEMICOLON; end
          lts_pkg::CH_STAR:   begin idle_emit = 1'b1; idle_type = lts_pkg::T_STAR; end
          lts_pkg::CH_BANG:   mode_d = lts_pkg::MODE_BANG;
          lts_pkg::CH_EQ:     mode_d = lts_pkg::MODE_EQ;
          lts_pkg::CH_LT:     mode_d = lts_pkg::MODE_LT;
          lts_pkg::CH_GT:     mode_d = lts_pkg::MODE_GT;
          lts_pkg::CH_SLASH:  mode_d = lts_pkg::MODE_SLASH;
          lts_pkg::CH_SPACE, lts_pkg::CH_CR, lts_pkg::CH_TAB: ;
          lts_pkg::CH_NL:     line_d = line_inc;
          lts_pkg::CH_QUOTE:  mode_d = lts_pkg::MODE_STR;
          default: begin
            if (lts_pkg::is_digit(c)) begin
              mode_d = lts_pkg::MODE_INT;
            end else if (lts_pkg::is_alpha(c)) begin
              mode_d = lts_pkg::MODE_IDENT;
            end else begin
              idle_emit = 1'b1;
              idle_err  = 1'b1;
            end
          end
        endcase
        if (idle_emit) begin
          res[n] = mk_res(idle_err, idle_err ? lts_pkg::T_LPAREN : idle_type,
                          idle_err ? lts_pkg::E_UNEXPECTED : lts_pkg::E_NONE,
                          p, POS_BITS'(1), line_q);
          n = n + 1'b1;
        end
      end
      pos_d = endp;
    end

    if (n != '0) res[n - 1'b1].last_of_run = 1'b1;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q  <= lts_pkg::MODE_IDLE;
      mark_q  <= lts_pkg::MARK_NONE;
      start_q <= '0;
      pos_q   <= '0;
      line_q  <= LINE_BITS'(1);
      nest_q  <= '0;
    end else begin
      mode_q  <= mode_d;
      mark_q  <= mark_d;
      start_q <= start_d;
      pos_q   <= pos_d;
      line_q  <= line_d;
      nest_q  <= nest_d;
    end
  end

  // --------------------------------------------------------------------------
  // Result queue: up to three pushes per transfer; while out_o is ready, one pop per cycle
  // --------------------------------------------------------------------------
  always_comb begin
    count_d = count_q + lts_pkg::CNT_BITS'(n) - lts_pkg::CNT_BITS'(out_fire);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q  <= '0;
      rptr_q  <= '0;
      count_q <= '0;
    end else begin
      wptr_q  <= wptr_q + lts_pkg::PTR_BITS'(n);
      rptr_q  <= rptr_q + lts_pkg::PTR_BITS'(out_fire);
      count_q <= count_d;
    end
  end

  // payload storage, no reset
  always_ff @(posedge clk_i) begin
    for (int i = 0; i < lts_pkg::MAX_PER_ITEM; i++) begin
      if (lts_pkg::SLOT_BITS'(i) < n) begin
        fifo_q[wptr_q + lts_pkg::PTR_BITS'(i)] <= res[i];
      end
    end
  end

  lts_pkg::lts_result_t head;
  assign head = fifo_q[rptr_q];

  assign out_o.valid       = (count_q != '0);
  assign out_o.is_error    = head.is_error;
  assign out_o.token_type  = head.token_type;
  assign out_o.error_code  = head.error_code;
  assign out_o.start_pos   = head.start_pos;
  assign out_o.token_len   = head.token_len;
  assign out_o.line_no     = head.line_no;
  assign out_o.last_of_run = head.last_of_run;

  // --------------------------------------------------------------------------
  // Assertions
  // --------------------------------------------------------------------------
  a_queue_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= lts_pkg::CNT_BITS'(lts_pkg::FIFO_DEPTH))
    else $error("result queue overflow");

  a_block_depth: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (mode_q == lts_pkg::MODE_BLOCK) |-> (nest_q != '0))
    else $error("block comment mode with zero depth");

  a_eos_resets: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_fire && in_i.action) |=>
      (mode_q == lts_pkg::MODE_IDLE && pos_q == '0 && line_q == LINE_BITS'(1) &&
       nest_q == '0))
    else $error("end of source did not return lexer to reset state");

  a_pos_step: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_fire && !in_i.action && pos_q != POS_ALL) |=>
      (pos_q == $past(pos_q) + POS_BITS'(1)))
    else $error("byte position did not advance");

  a_eof_len: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_o.valid && !out_o.is_error && out_o.token_type == lts_pkg::T_EOF) |->
      (out_o.token_len == '0 && out_o.last_of_run))
    else $error("malformed end-of-file token");

endmodule

FILE: sim/tb_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the lexical token scanner. A behavioral scanner
// inside a small scoreboard class predicts the tokens and error reports of
// every accepted source byte or end of source. Each result leaving the block
// is compared field by field with the oldest prediction. Stimulus is a short
// set of hand-written sources, one deep nested comment, then random
// source programs mixed with noise. Both handshakes are throttled at random,
// and there is one long output stall and drain pauses between phases.
// ----------------------------------------------------------------------------
module tb_top;

  typedef logic [lts_pkg::OUT_BITS-1:0]  pos_t;
  typedef logic [lts_pkg::TYPE_BITS-1:0] ttype_t;
  typedef logic [lts_pkg::CODE_BITS-1:0] code_t;

  localparam pos_t       SAT_MAX      = '1;
  localparam logic [7:0] DEPTH_MAX    = '1;
  localparam int         MAX_RESULTS  = 4;
  localparam int         RANDOM_ITEMS = 264;
  localparam int         PHASE_ITEMS  = RANDOM_ITEMS / 3;
  localparam int         HOLD_CYCLES  = 300;
  localparam int         DEEP_LEVELS  = 20;

  // --------------------------------------------------------------------------
  // Scoreboard: a behavioral scanner plus the queue of tokens still due
  // --------------------------------------------------------------------------
  class token_checker;
    lts_pkg::lts_mode_e   mode;
    pos_t                 tok_start;
    pos_t                 pos;
    pos_t                 line;
    logic [7:0]           depth;
    lts_pkg::lts_mark_e   mark;
    lts_pkg::lts_result_t item_tokens[$];
    lts_pkg::lts_result_t tokens_due[$];
    int                   errors;

    function new();
      errors = 0;
      clear_state();
    endfunction

    function void clear_state();
      mode      = lts_pkg::MODE_IDLE;
      tok_start = '0;
      pos       = '0;
      line      = pos_t'(1);
      depth     = '0;
      mark      = lts_pkg::MARK_NONE;
    endfunction

    function int pending();
      return tokens_due.size();
    endfunction

    function bit failed();
      return errors != 0;
    endfunction

    function bit digit_char(logic [7:0] c);
      return c >= lts_pkg::CH_0 && c <= lts_pkg::CH_9;
    endfunction

    function bit word_char(logic [7:0] c);
      return (c >= lts_pkg::CH_LA && c <= lts_pkg::CH_LZ) ||
             (c >= lts_pkg::CH_UA && c <= lts_pkg::CH_UZ) ||
             c == lts_pkg::CH_UNDER;
    endfunction

    function pos_t lexeme_len(pos_t end_pos);
      return end_pos >= tok_start ? end_pos - tok_start : '0;
    endfunction

    // one-char type of a pending ! = < >; the two-char form is type + 1
    function ttype_t op_one_char(lts_pkg::lts_mode_e m);
      case (m)
        lts_pkg::MODE_EQ: return lts_pkg::T_EQUAL;
        lts_pkg::MODE_LT: return lts_pkg::T_LESS;
        lts_pkg::MODE_GT: return lts_pkg::T_GREATER;
        default:          return lts_pkg::T_BANG;
      endcase
    endfunction

    function void add_token(logic err, ttype_t typ, code_t code, pos_t start,
                            pos_t len);
      lts_pkg::lts_result_t r;
      r.is_error    = err;
      r.token_type  = typ;
      r.error_code  = code;
      r.start_pos   = start;
      r.token_len   = len;
      r.line_no     = line;
      r.last_of_run = 1'b0;
      if (item_tokens.size() < MAX_RESULTS) item_tokens.insert(item_tokens.size(), r);
    endfunction

    // single-character token at p
    function void add_single(ttype_t typ, pos_t p);
      add_token(1'b0, typ, lts_pkg::E_NONE, p, pos_t'(1));
    endfunction

    // "12." then a non-digit: number without the dot, then the dot
    function void number_then_dot(pos_t p);
      pos_t dot_pos;
      dot_pos = p > tok_start ? p - pos_t'(1) : p;
      add_token(1'b0, lts_pkg::T_NUMBER, lts_pkg::E_NONE, tok_start,
                lexeme_len(dot_pos));
      add_single(lts_pkg::T_DOT, dot_pos);
    endfunction

    function void lex_idle(logic [7:0] c, pos_t p);
      tok_start = p;
      case (c)
        lts_pkg::CH_LPAREN: add_single(lts_pkg::T_LPAREN, p);
        lts_pkg::CH_RPAREN: add_single(lts_pkg::T_RPAREN, p);
        lts_pkg::CH_LBRACE: add_single(lts_pkg::T_LBRACE, p);
        lts_pkg::CH_RBRACE: add_single(lts_pkg::T_RBRACE, p);
        lts_pkg::CH_COMMA:  add_single(lts_pkg::T_COMMA, p);
        lts_pkg::CH_DOT:    add_single(lts_pkg::T_DOT, p);
        lts_pkg::CH_MINUS:  add_single(lts_pkg::T_MINUS, p);
        lts_pkg::CH_PLUS:   add_single(lts_pkg::T_PLUS, p);
        lts_pkg::CH_SEMI:   add_single(lts_pkg::T_SEMICOLON, p);
        lts_pkg::CH_STAR:   add_single(lts_pkg::T_STAR, p);
        lts_pkg::CH_BANG:   mode = lts_pkg::MODE_BANG;
        lts_pkg::CH_EQ:     mode = lts_pkg::MODE_EQ;
        lts_pkg::CH_LT:     mode = lts_pkg::MODE_LT;
        lts_pkg::CH_GT:     mode = lts_pkg::MODE_GT;
        lts_pkg::CH_SLASH:  mode = lts_pkg::MODE_SLASH;
        lts_pkg::CH_SPACE, lts_pkg::CH_CR, lts_pkg::CH_TAB: ;
        lts_pkg::CH_NL:     if (line != SAT_MAX) line++;
        lts_pkg::CH_QUOTE:  mode = lts_pkg::MODE_STR;
        default: begin
          if (digit_char(c)) mode = lts_pkg::MODE_INT;
          else if (word_char(c)) mode = lts_pkg::MODE_IDENT;
          else add_token(1'b1, '0, lts_pkg::E_UNEXPECTED, p, pos_t'(1));
        end
      endcase
    endfunction

    function void lex_comment(logic [7:0] c);
      if (mark == lts_pkg::MARK_STAR && c == lts_pkg::CH_SLASH) begin
        if (depth != 0) depth--;
        mark = lts_pkg::MARK_NONE;
        if (depth == 0) mode = lts_pkg::MODE_IDLE;
        return;
      end
      if (mark == lts_pkg::MARK_SLASH && c == lts_pkg::CH_STAR) begin
        if (depth != DEPTH_MAX) depth++;
        mark = lts_pkg::MARK_NONE;
        return;
      end
      if (c == lts_pkg::CH_NL && line != SAT_MAX) line++;
      if (c == lts_pkg::CH_STAR)       mark = lts_pkg::MARK_STAR;
      else if (c == lts_pkg::CH_SLASH) mark = lts_pkg::MARK_SLASH;
      else                             mark = lts_pkg::MARK_NONE;
    endfunction

    function void flush_source();
      case (mode)
        lts_pkg::MODE_BANG, lts_pkg::MODE_EQ, lts_pkg::MODE_LT, lts_pkg::MODE_GT:
          add_token(1'b0, op_one_char(mode), lts_pkg::E_NONE, tok_start,
                    lexeme_len(pos));
        lts_pkg::MODE_SLASH:
          add_token(1'b0, lts_pkg::T_SLASH, lts_pkg::E_NONE, tok_start,
                    lexeme_len(pos));
        lts_pkg::MODE_BLOCK:
          add_token(1'b1, '0,
                    depth == 8'd1 ? lts_pkg::E_OPEN_CMT : lts_pkg::E_OPEN_NESTED,
                    tok_start, lexeme_len(pos));
        lts_pkg::MODE_STR:
          add_token(1'b1, '0, lts_pkg::E_OPEN_STRING, tok_start, lexeme_len(pos));
        lts_pkg::MODE_INT, lts_pkg::MODE_FRAC:
          add_token(1'b0, lts_pkg::T_NUMBER, lts_pkg::E_NONE, tok_start,
                    lexeme_len(pos));
        lts_pkg::MODE_DOT:
          number_then_dot(pos);
        lts_pkg::MODE_IDENT:
          add_token(1'b0, lts_pkg::T_IDENT, lts_pkg::E_NONE, tok_start,
                    lexeme_len(pos));
        default: ;
      endcase
      add_token(1'b0, lts_pkg::T_EOF, lts_pkg::E_NONE, pos, '0);
      clear_state();
    endfunction

    // Predict the results of one accepted input transfer
    function void scan_item(logic act, logic [7:0] c);
      pos_t   p;
      pos_t   end_pos;
      ttype_t t;
      bit     again;
      item_tokens.delete();
      if (act) begin
        flush_source();
      end else begin
        p       = pos;
        end_pos = pos != SAT_MAX ? pos + pos_t'(1) : pos;
        again   = 1'b0;
        case (mode)
          lts_pkg::MODE_IDLE: lex_idle(c, p);
          lts_pkg::MODE_BANG, lts_pkg::MODE_EQ, lts_pkg::MODE_LT,
          lts_pkg::MODE_GT: begin
            t    = op_one_char(mode);
            mode = lts_pkg::MODE_IDLE;
            if (c == lts_pkg::CH_EQ) begin
              add_token(1'b0, t + 1'b1, lts_pkg::E_NONE, tok_start,
                        lexeme_len(end_pos));
            end else begin
              add_token(1'b0, t, lts_pkg::E_NONE, tok_start, lexeme_len(p));
              again = 1'b1;
            end
          end
          lts_pkg::MODE_SLASH: begin
            if (c == lts_pkg::CH_SLASH) begin
              mode = lts_pkg::MODE_LINE;
            end else if (c == lts_pkg::CH_STAR) begin
              mode  = lts_pkg::MODE_BLOCK;
              depth = 8'd1;
              mark  = lts_pkg::MARK_NONE;
            end else begin
              mode = lts_pkg::MODE_IDLE;
              add_token(1'b0, lts_pkg::T_SLASH, lts_pkg::E_NONE, tok_start,
                        lexeme_len(p));
              again = 1'b1;
            end
          end
          lts_pkg::MODE_LINE: begin
            if (c == lts_pkg::CH_NL) begin
              mode  = lts_pkg::MODE_IDLE;
              again = 1'b1;
            end
          end
          lts_pkg::MODE_BLOCK: lex_comment(c);
          lts_pkg::MODE_STR: begin
            if (c == lts_pkg::CH_QUOTE) begin
              mode = lts_pkg::MODE_IDLE;
              add_token(1'b0, lts_pkg::T_STRING, lts_pkg::E_NONE, tok_start,
                        lexeme_len(end_pos));
            end else if (c == lts_pkg::CH_NL && line != SAT_MAX) begin
              line++;
            end
          end
          lts_pkg::MODE_INT: begin
            if (c == lts_pkg::CH_DOT) begin
              mode = lts_pkg::MODE_DOT;
            end else if (!digit_char(c)) begin
              mode = lts_pkg::MODE_IDLE;
              add_token(1'b0, lts_pkg::T_NUMBER, lts_pkg::E_NONE, tok_start,
                        lexeme_len(p));
              again = 1'b1;
            end
          end
          lts_pkg::MODE_DOT: begin
            if (digit_char(c)) begin
              mode = lts_pkg::MODE_FRAC;
            end else begin
              mode = lts_pkg::MODE_IDLE;
              number_then_dot(p);
              again = 1'b1;
            end
          end
          lts_pkg::MODE_FRAC: begin
            if (!digit_char(c)) begin
              mode = lts_pkg::MODE_IDLE;
              add_token(1'b0, lts_pkg::T_NUMBER, lts_pkg::E_NONE, tok_start,
                        lexeme_len(p));
              again = 1'b1;
            end
          end
          lts_pkg::MODE_IDENT: begin
            if (!word_char(c) && !digit_char(c)) begin
              mode = lts_pkg::MODE_IDLE;
              add_token(1'b0, lts_pkg::T_IDENT, lts_pkg::E_NONE, tok_start,
                        lexeme_len(p));
              again = 1'b1;
            end
          end
          default: begin
            mode  = lts_pkg::MODE_IDLE;
            again = 1'b1;
          end
        endcase
        if (again) lex_idle(c, p);
        pos = end_pos;
      end
      if (item_tokens.size() > 0)
        item_tokens[item_tokens.size() - 1].last_of_run = 1'b1;
      foreach (item_tokens[i]) tokens_due.insert(tokens_due.size(), item_tokens[i]);
    endfunction

    function void match_token(lts_pkg::lts_result_t got);
      lts_pkg::lts_result_t exp;
      bit                   bad;
      if (tokens_due.size() == 0) begin
        errors++;
        if (errors <= 10)
          $display("[%0t] result with nothing due: err=%0d type=%0d code=%0d start=%0d",
                   $time, got.is_error, got.token_type, got.error_code,
                   got.start_pos);
        return;
      end
      exp = tokens_due.pop_front();
      bad = (got.is_error !== exp.is_error) || (got.token_type !== exp.token_type) ||
            (got.error_code !== exp.error_code) || (got.start_pos !== exp.start_pos) ||
            (got.token_len !== exp.token_len) || (got.line_no !== exp.line_no) ||
            (got.last_of_run !== exp.last_of_run);
      if (bad) begin
        errors++;
        if (errors <= 10) begin
          $display("[%0t] mismatch: exp err=%0d type=%0d code=%0d start=%0d",
                   $time, exp.is_error, exp.token_type, exp.error_code,
                   exp.start_pos);
          $display("            exp len=%0d line=%0d last=%0d",
                   exp.token_len, exp.line_no, exp.last_of_run);
          $display("            got err=%0d type=%0d code=%0d start=%0d",
                   got.is_error, got.token_type, got.error_code, got.start_pos);
          $display("            got len=%0d line=%0d last=%0d",
                   got.token_len, got.line_no, got.last_of_run);
        end
      end
    endfunction
  endclass

  // --------------------------------------------------------------------------
  // Clock, reset, channels and the block
  // --------------------------------------------------------------------------
  logic clk_i;
  logic rst_ni;

  lts_in_if  in_if ();
  lts_out_if out_if ();

  lexical_token_scanner DUT (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (in_if),
    .out_o  (out_if)
  );

  token_checker sb = new();

  int         tx_idle_pct = 0;   // sender gap odds, percent per cycle
  int         rx_idle_pct = 0;   // receiver stall odds, percent per cycle
  int         hold_left   = 0;   // long receiver hold-off, cycles left
  int         items_sent  = 0;
  logic [7:0] src_q[$];          // source bytes of the program being built

  // append one byte to the program being built
  function automatic void queue_byte(input logic [7:0] b);
    src_q.insert(src_q.size(), b);
  endfunction

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  initial begin
    rst_ni = 1'b0;
    repeat (2) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
  end

  // Generous cap: the slowest legal run is well under a tenth of this
  initial begin
    #3ms;
    $display("lexical_token_scanner regression: fail");
    $finish;
  end

  // Receiver: random stalls, or a counted hold-off when one is requested
  initial begin
    out_if.ready <= 1'b0;
    @(posedge rst_ni);
    forever begin
      @(negedge clk_i);
      if (hold_left > 0) begin
        hold_left--;
        out_if.ready <= 1'b0;
      end else begin
        out_if.ready <= ($urandom_range(0, 99) >= rx_idle_pct);
      end
    end
  end

  // Output monitor: every transfer is checked against the oldest prediction
  always @(posedge clk_i) begin
    if (rst_ni && out_if.valid && out_if.ready) begin
      sb.match_token('{is_error:    out_if.is_error,
                       token_type:  out_if.token_type,
                       error_code:  out_if.error_code,
                       start_pos:   out_if.start_pos,
                       token_len:   out_if.token_len,
                       line_no:     out_if.line_no,
                       last_of_run: out_if.last_of_run});
    end
  end

  // --------------------------------------------------------------------------
  // Driving tasks. Each starts and ends at a falling edge; valid is only
  // lowered by a gap or a drain, never right before it is raised again.
  // --------------------------------------------------------------------------
  task automatic send_item(input logic act, input logic [7:0] b);
    while ($urandom_range(0, 99) < tx_idle_pct) begin
      in_if.valid <= 1'b0;
      @(negedge clk_i);
    end
    in_if.valid    <= 1'b1;
    in_if.action   <= act;
    in_if.byte_req <= b;
    @(posedge clk_i);
    while (!in_if.ready) @(posedge clk_i);
    sb.scan_item(act, b);
    items_sent++;
    @(negedge clk_i);
  endtask

  // end of source: the byte field is don't-care, so it gets noise
  task automatic send_eos();
    send_item(1'b1, 8'($urandom_range(0, 255)));
  endtask

  task automatic send_text(input string s);
    for (int i = 0; i < s.len(); i++) send_item(1'b0, s[i]);
  endtask

  task automatic send_queued();
    while (src_q.size() > 0) send_item(1'b0, src_q.pop_front());
  endtask

  // stop offering and wait until every predicted token has been seen
  task automatic drain();
    in_if.valid <= 1'b0;
    do @(negedge clk_i); while (sb.pending() != 0);
  endtask

  // --------------------------------------------------------------------------
  // Random source text
  // --------------------------------------------------------------------------
  function automatic logic [7:0] pick_alpha();
    int k;
    k = $urandom_range(0, 52);
    if (k < 26) return lts_pkg::CH_LA + 8'(k);
    if (k < 52) return lts_pkg::CH_UA + 8'(k - 26);
    return lts_pkg::CH_UNDER;
  endfunction

  function automatic logic [7:0] pick_digit();
    return lts_pkg::CH_0 + 8'($urandom_range(0, 9));
  endfunction

  function automatic logic [7:0] pick_alnum();
    if ($urandom_range(0, 3) == 0) return pick_digit();
    return pick_alpha();
  endfunction

  // printable text without quotes; newline now and then
  function automatic logic [7:0] pick_text();
    logic [7:0] c;
    if ($urandom_range(0, 7) == 0) return lts_pkg::CH_NL;
    c = 8'($urandom_range(32, 126));
    return c == lts_pkg::CH_QUOTE ? lts_pkg::CH_SPACE : c;
  endfunction

  function automatic logic [7:0] pick_single_op();
    case ($urandom_range(0, 9))
      0: return lts_pkg::CH_LPAREN;
      1: return lts_pkg::CH_RPAREN;
      2: return lts_pkg::CH_LBRACE;
      3: return lts_pkg::CH_RBRACE;
      4: return lts_pkg::CH_COMMA;
      5: return lts_pkg::CH_DOT;
      6: return lts_pkg::CH_MINUS;
      7: return lts_pkg::CH_PLUS;
      8: return lts_pkg::CH_SEMI;
      default: return lts_pkg::CH_STAR;
    endcase
  endfunction

  function automatic logic [7:0] pick_space();
    case ($urandom_range(0, 3))
      0: return lts_pkg::CH_TAB;
      1: return lts_pkg::CH_CR;
      2: return lts_pkg::CH_NL;
      default: return lts_pkg::CH_SPACE;
    endcase
  endfunction

  // well-formed nested comment; content never forms an open or close pair
  task automatic add_block_comment(input int lvl);
    queue_byte(lts_pkg::CH_SLASH);
    queue_byte(lts_pkg::CH_STAR);
    repeat ($urandom_range(0, 4)) begin
      case ($urandom_range(0, 3))
        0: queue_byte(pick_space());
        1: begin
          queue_byte(lts_pkg::CH_STAR);
          queue_byte(pick_alpha());
        end
        2: if (lvl < 3) add_block_comment(lvl + 1);
        default: queue_byte(pick_alnum());
      endcase
    end
    queue_byte(lts_pkg::CH_STAR);
    queue_byte(lts_pkg::CH_SLASH);
  endtask

  task automatic add_lexeme();
    case ($urandom_range(0, 11))
      0, 1: queue_byte(pick_single_op());
      2: begin
        case ($urandom_range(0, 3))
          0: queue_byte(lts_pkg::CH_BANG);
          1: queue_byte(lts_pkg::CH_EQ);
          2: queue_byte(lts_pkg::CH_LT);
          default: queue_byte(lts_pkg::CH_GT);
        endcase
        if ($urandom_range(0, 1)) queue_byte(lts_pkg::CH_EQ);
      end
      3, 4: begin
        queue_byte(pick_alpha());
        repeat ($urandom_range(0, 6)) queue_byte(pick_alnum());
      end
      5: begin
        repeat ($urandom_range(1, 4)) queue_byte(pick_digit());
        // a bare trailing dot is the number-then-dot case unless a digit follows
        if ($urandom_range(0, 2) == 0) begin
          queue_byte(lts_pkg::CH_DOT);
          repeat ($urandom_range(0, 3)) queue_byte(pick_digit());
        end
      end
      6: begin
        queue_byte(lts_pkg::CH_QUOTE);
        repeat ($urandom_range(0, 6)) queue_byte(pick_text());
        queue_byte(lts_pkg::CH_QUOTE);
      end
      7: queue_byte(pick_space());
      8: begin
        queue_byte(lts_pkg::CH_SLASH);
        queue_byte(lts_pkg::CH_SLASH);
        repeat ($urandom_range(0, 5)) queue_byte(8'($urandom_range(32, 126)));
        queue_byte(lts_pkg::CH_NL);
      end
      9: add_block_comment(1);
      10: queue_byte(lts_pkg::CH_SLASH);
      default: queue_byte(8'($urandom_range(0, 255)));   // noise
    endcase
  endtask

  // one program: lexemes, sometimes an open string or comment, end of source
  task automatic send_program();
    repeat ($urandom_range(3, 12)) begin
      add_lexeme();
      if ($urandom_range(0, 2) == 0) queue_byte(pick_space());
    end
    case ($urandom_range(0, 7))
      0: begin
        queue_byte(lts_pkg::CH_QUOTE);
        repeat ($urandom_range(0, 4)) queue_byte(pick_text());
      end
      1: begin
        repeat ($urandom_range(1, 3)) begin
          queue_byte(lts_pkg::CH_SLASH);
          queue_byte(lts_pkg::CH_STAR);
          queue_byte(pick_alnum());
        end
      end
      default: ;
    endcase
    send_queued();
    send_eos();
  endtask

  // --------------------------------------------------------------------------
  // Stimulus
  // --------------------------------------------------------------------------
  initial begin
    int random_base;
    in_if.valid    <= 1'b0;
    in_if.action   <= 1'b0;
    in_if.byte_req <= 8'h00;
    @(posedge rst_ni);
    @(negedge clk_i);

    // Directed part, light throttling on both sides
    tx_idle_pct = 18;
    rx_idle_pct = 18;
    send_eos();                           // empty source
    send_item(1'b0, 8'h00);               // lowest and highest bytes: unexpected
    send_item(1'b0, 8'hFF);
    send_eos();
    send_text("12.x");                    // number, then the dot on its own
    send_eos();
    send_text("/*/**/*/*");               // a close eats its slash; star token after
    send_eos();
    send_text("/*/*");                    // open nested comment at end
    send_eos();
    send_text("/*\n");                    // open comment at depth one
    send_eos();
    send_text("\"a\n");                   // open string across a newline
    send_eos();
    send_text("!=<>=/");                  // two-char ops, slash pending at end
    send_eos();
    send_text("4.5//c\n=");               // fraction, line comment, pending '='
    send_eos();

    // Deep nesting, partly closed, still open at end of source
    for (int i = 0; i < DEEP_LEVELS; i++) send_text("/*");
    send_text("*/*/*/");
    send_eos();
    drain();

    // Random programs in three throttling phases
    random_base = items_sent;
    tx_idle_pct = 18;
    rx_idle_pct = 75;
    while (items_sent - random_base < PHASE_ITEMS) send_program();
    drain();                              // sender pauses until all tokens are out

    tx_idle_pct = 75;
    rx_idle_pct = 18;
    while (items_sent - random_base < 2 * PHASE_ITEMS) send_program();
    drain();

    // Long receiver hold-off while bytes keep coming: the input backs up
    tx_idle_pct = 0;
    rx_idle_pct = 0;
    hold_left   = HOLD_CYCLES;
    while (items_sent - random_base < RANDOM_ITEMS) send_program();

    drain();
    repeat (20) @(negedge clk_i);         // catch any stray late results
    if (!sb.failed()) begin
      $display("lexical_token_scanner regression: pass");
    end else begin
      $display("lexical_token_scanner regression: fail");
    end
    $finish;
  end

endmodule
